### rtl/legendre_polynomial_sequence_macros.svh
// assertion helpers shared by the legendre sequence rtl
`ifndef LEGENDRE_POLYNOMIAL_SEQUENCE_MACROS_SVH
`define LEGENDRE_POLYNOMIAL_SEQUENCE_MACROS_SVH

// same-cycle implication
`define LPS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("lps: same-cycle check failed");

// next-cycle implication
`define LPS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("lps: next-cycle check failed");

`endif

### rtl/lps_pkg.sv
`default_nettype none

package lps_pkg;

  localparam int FRAC_BITS = 30;
  localparam int X_W       = FRAC_BITS + 1;
  localparam int VAL_W     = FRAC_BITS + 2;
  localparam int DEG_W     = 6;
  localparam int MAG_W     = FRAC_BITS + 1;
  localparam int PROD_W    = 2 * MAG_W;
  localparam int TERM_W    = PROD_W + DEG_W + 1;
  localparam int RADIX_W   = 8;
  localparam int QUO_W     = 40;
  localparam int DIV_STEPS = QUO_W / RADIX_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [MAG_W-1:0] ONE_MAG = {1'b1, {FRAC_BITS{1'b0}}};

  typedef struct packed {
    logic load;
    logic shift_x;
    logic mul;
    logic scale;
    logic sum;
    logic load_div;
    logic div_step;
    logic write;
  } lps_cmd_t;

  typedef struct packed {
    logic first;
    logic last;
  } lps_stat_t;

endpackage

`default_nettype wire

### rtl/lps_datapath.sv
`default_nettype none
`include "legendre_polynomial_sequence_macros.svh"

module lps_datapath import lps_pkg::*; #(
  parameter int MAX_DEGREE = 63
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire lps_cmd_t                cmd_i,
  output lps_stat_t                    stat_o,
  input  wire logic signed [X_W-1:0]   x_value_i,
  input  wire logic        [DEG_W-1:0] degree_i,
  output logic signed [VAL_W-1:0]      poly_value_o,
  output logic        [DEG_W-1:0]      poly_index_o,
  output logic                         last_o
);

  logic [MAG_W-1:0]  x_mag_q, cur_mag_q, prev_mag_q;
  logic              x_neg_q, cur_neg_q, prev_neg_q;
  logic [DEG_W-1:0]  k_q, deg_q;
  logic [PROD_W-1:0] prod_q;
  logic [TERM_W-1:0] term_a_q, term_b_q, num_q;
  logic              num_neg_q;
  logic [QUO_W-1:0]  div_q, div_d;
  logic [DEG_W-1:0]  rem_q, rem_d;

  logic [MAG_W-1:0]  x_abs, x_mag_d, new_mag;
  logic [DEG_W-1:0]  deg_d;
  logic [DEG_W:0]    odd_w, dsr_w;
  logic              a_neg, b_neg;
  logic [TERM_W-1:0] num_d, rnd_sum;
  logic              num_neg_d;

  // argument clamp and degree limit
  always_comb begin
    x_abs   = x_value_i[X_W-1] ? MAG_W'(~x_value_i + 1'b1) : MAG_W'(x_value_i);
    x_mag_d = (x_abs > ONE_MAG) ? ONE_MAG : x_abs;
    deg_d   = (degree_i > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : degree_i;
  end

  assign odd_w = {k_q, 1'b1};
  assign dsr_w = {1'b0, k_q} + 1'b1;

  // signed-magnitude combine of (2k+1)*x*p and -k*q*one
  always_comb begin
    a_neg = x_neg_q ^ cur_neg_q;
    b_neg = ~prev_neg_q;
    if (a_neg == b_neg) begin
      num_d     = term_a_q + term_b_q;
      num_neg_d = a_neg;
    end else if (term_a_q >= term_b_q) begin
      num_d     = term_a_q - term_b_q;
      num_neg_d = a_neg;
    end else begin
      num_d     = term_b_q - term_a_q;
      num_neg_d = b_neg;
    end
  end

  // half the divisor folded in ahead so the quotient comes out rounded
  assign rnd_sum = num_q + (TERM_W'(dsr_w) << (FRAC_BITS - 1));

  // radix-256 restoring step, quotient bits shift in behind the dividend
  always_comb begin
    logic [DEG_W:0]   t;
    logic [QUO_W-1:0] sh;
    logic [DEG_W-1:0] r;
    sh = div_q;
    r  = rem_q;
    for (int i = 0; i < RADIX_W; i++) begin
      t  = {r, sh[QUO_W-1]};
      sh = {sh[QUO_W-2:0], 1'b0};
      if (t >= dsr_w) begin
        t     = t - dsr_w;
        sh[0] = 1'b1;
      end
      r = t[DEG_W-1:0];
    end
    div_d = sh;
    rem_d = r;
  end

  assign new_mag = (div_q > QUO_W'(ONE_MAG)) ? ONE_MAG : div_q[MAG_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_mag_q  <= '0;
      cur_neg_q  <= 1'b0;
      prev_mag_q <= '0;
      prev_neg_q <= 1'b0;
      k_q        <= '0;
      deg_q      <= '0;
    end else if (cmd_i.load) begin
      cur_mag_q <= ONE_MAG;
      cur_neg_q <= 1'b0;
      k_q       <= '0;
      deg_q     <= deg_d;
    end else if (cmd_i.shift_x) begin
      prev_mag_q <= cur_mag_q;
      prev_neg_q <= cur_neg_q;
      cur_mag_q  <= x_mag_q;
      cur_neg_q  <= x_neg_q;
      k_q        <= k_q + 1'b1;
    end else if (cmd_i.write) begin
      prev_mag_q <= cur_mag_q;
      prev_neg_q <= cur_neg_q;
      cur_mag_q  <= new_mag;
      cur_neg_q  <= num_neg_q && (new_mag != '0);
      k_q        <= k_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_mag_q <= x_mag_d;
      x_neg_q <= x_value_i[X_W-1] && (x_mag_d != '0);
    end
    if (cmd_i.mul) begin
      prod_q <= x_mag_q * cur_mag_q;
    end
    if (cmd_i.scale) begin
      term_a_q <= TERM_W'(prod_q) * TERM_W'(odd_w);
      term_b_q <= (TERM_W'(prev_mag_q) * TERM_W'(k_q)) << FRAC_BITS;
    end
    if (cmd_i.sum) begin
      num_q     <= num_d;
      num_neg_q <= num_neg_d;
    end
    if (cmd_i.load_div) begin
      div_q <= QUO_W'(rnd_sum[TERM_W-1:FRAC_BITS]);
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      div_q <= div_d;
      rem_q <= rem_d;
    end
  end

  assign stat_o.first  = (k_q == '0);
  assign stat_o.last   = (k_q == deg_q);
  assign poly_value_o  = cur_neg_q ? -VAL_W'(cur_mag_q) : VAL_W'(cur_mag_q);
  assign poly_index_o  = k_q;
  assign last_o        = (k_q == deg_q);

  `LPS_ASSERT_IMP(cur_sat_a, clk_i, rst_ni, 1'b1, cur_mag_q <= ONE_MAG)
  `LPS_ASSERT_IMP(idx_le_deg_a, clk_i, rst_ni, 1'b1, k_q <= deg_q)

endmodule

`default_nettype wire

### rtl/lps_ctrl.sv
`default_nettype none
`include "legendre_polynomial_sequence_macros.svh"

module lps_ctrl import lps_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  input  wire lps_stat_t stat_i,
  output lps_cmd_t       cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_EMIT  = 8'b0000_0010,
    S_MUL   = 8'b0000_0100,
    S_SCALE = 8'b0000_1000,
    S_SUM   = 8'b0001_0000,
    S_LOAD  = 8'b0010_0000,
    S_DIV   = 8'b0100_0000,
    S_WRITE = 8'b1000_0000
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EMIT;
        end
      end
      S_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (stat_i.last) begin
            state_d = S_IDLE;
          end else if (stat_i.first) begin
            // second beat is x itself
            cmd_o.shift_x = 1'b1;
          end else begin
            state_d = S_MUL;
          end
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_SCALE;
      end
      S_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = S_LOAD;
      end
      S_LOAD: begin
        cmd_o.load_div = 1'b1;
        cnt_d          = '0;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd_o.write = 1'b1;
        state_d     = S_EMIT;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  `LPS_ASSERT_IMP(ready_valid_excl_a, clk_i, rst_ni, in_ready_o, !out_valid_o)
  `LPS_ASSERT_NXT(in_beat_emits_a, clk_i, rst_ni, in_valid_i && in_ready_o, out_valid_o)
  `LPS_ASSERT_NXT(last_beat_idles_a, clk_i, rst_ni,
                  out_valid_o && out_ready_i && stat_i.last, in_ready_o)

endmodule

`default_nettype wire

### rtl/legendre_polynomial_sequence.sv
// channel | handshake             | payload
// input   | in_valid_i/in_ready_o | x_value_i (s31 Q1.30), degree_i (u6)
// output  | out_valid_o/out_ready_i | poly_value_o (s32 Q2.30), poly_index_o, last_o
//
// one request gives degree+1 beats, P0 first; a new request is taken only once the
// beat marked last has been taken.
// P1 is x itself and needs no recurrence; each later degree runs the recurrence
// (multiply, scale, combine, rounding add, radix-256 divide steps, write) before
// its output beat is offered.
// stalls on the output hold the recurrence; reset returns the controller to idle.
`default_nettype none

module legendre_polynomial_sequence import lps_pkg::*; #(
  parameter int MAX_DEGREE = 63
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic signed [X_W-1:0]   x_value_i,
  input  wire logic        [DEG_W-1:0] degree_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic signed [VAL_W-1:0]      poly_value_o,
  output logic        [DEG_W-1:0]      poly_index_o,
  output logic                         last_o
);

  lps_cmd_t  cmd;
  lps_stat_t stat;

  lps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  lps_datapath #(
    .MAX_DEGREE (MAX_DEGREE)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .x_value_i    (x_value_i),
    .degree_i     (degree_i),
    .poly_value_o (poly_value_o),
    .poly_index_o (poly_index_o),
    .last_o       (last_o)
  );

endmodule

`default_nettype wire

### test/testbench.sv
import lps_pkg::*;

module testbench;

  localparam logic signed [VAL_W-1:0] ONE_Q = VAL_W'(2 ** FRAC_BITS);
  localparam logic signed [X_W-1:0]   X_MIN = X_W'(-(2 ** FRAC_BITS));
  localparam logic signed [X_W-1:0]   X_MAX = X_W'(2 ** FRAC_BITS - 1);
  localparam int                      TOP_DEGREE = 63;
  localparam int                      RANDOM_REQUESTS = 480;

  logic                    clk_i;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic signed [X_W-1:0]   x_value_i = '0;
  logic        [DEG_W-1:0] degree_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic signed [VAL_W-1:0] poly_value_o;
  logic        [DEG_W-1:0] poly_index_o;
  logic                    last_o;

  bit no_idle = 1'b0;
  bit hold_sink = 1'b0;

  typedef struct {
    logic signed [VAL_W-1:0] value;
    logic        [DEG_W-1:0] index;
    logic                    last;
  } legendre_term_t;

  class legendre_ledger;
    legendre_term_t awaited_terms[$];
    int             mismatches = 0;

    // one step of the three-term recurrence, numerator exact, rounded division
    function automatic logic signed [VAL_W-1:0] recurrence_next(
        logic signed [VAL_W-1:0] x, logic signed [VAL_W-1:0] p,
        logic signed [VAL_W-1:0] q, int k);
      logic signed [127:0] xs, ps, qs, ks, acc;
      logic        [127:0] mag, den, quo, rem;
      xs = 128'(x);
      ps = 128'(p);
      qs = 128'(q);
      ks = 128'(k);
      acc = xs * ps * (2 * ks + 1) - ((qs * ks) <<< FRAC_BITS);
      mag = acc[127] ? -acc : acc;
      den = 128'(k + 1) << FRAC_BITS;
      quo = mag / den;
      rem = mag % den;
      if ((rem << 1) >= den) quo = quo + 1;
      if (quo > 128'(ONE_Q)) quo = 128'(ONE_Q);
      return acc[127] ? -VAL_W'(quo) : VAL_W'(quo);
    endfunction

    function void note_request(logic signed [X_W-1:0] x_raw, logic [DEG_W-1:0] deg_raw);
      logic signed [VAL_W-1:0] x, cur, prev, nxt;
      int                      deg;
      legendre_term_t          t;
      x = VAL_W'(x_raw);
      if (x > ONE_Q) x = ONE_Q;
      if (x < -ONE_Q) x = -ONE_Q;
      deg = int'(deg_raw);
      if (deg > TOP_DEGREE) deg = TOP_DEGREE;
      t.value = ONE_Q;
      t.index = '0;
      t.last  = (deg == 0);
      awaited_terms.push_back(t);
      prev = ONE_Q;
      cur  = x;
      for (int k = 1; k <= deg; k++) begin
        t.value = cur;
        t.index = DEG_W'(k);
        t.last  = (k == deg);
        awaited_terms.push_back(t);
        if (k < deg) begin
          nxt  = recurrence_next(x, cur, prev, k);
          prev = cur;
          cur  = nxt;
        end
      end
    endfunction

    function void check_term(logic signed [VAL_W-1:0] value, logic [DEG_W-1:0] index,
                             logic last);
      legendre_term_t t;
      if (awaited_terms.size() == 0) begin
        $display("%0t: unexpected beat value %0d index %0d last %0b",
                 $time, value, index, last);
        mismatches++;
        return;
      end
      t = awaited_terms.pop_front();
      if (value !== t.value) begin
        $display("%0t: poly_value expected %0d got %0d", $time, t.value, value);
        mismatches++;
      end
      if (index !== t.index) begin
        $display("%0t: poly_index expected %0d got %0d", $time, t.index, index);
        mismatches++;
      end
      if (last !== t.last) begin
        $display("%0t: last expected %0b got %0b", $time, t.last, last);
        mismatches++;
      end
    endfunction
  endclass

  legendre_ledger ledger = new();

  legendre_polynomial_sequence uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .x_value_i    (x_value_i),
    .degree_i     (degree_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .poly_value_o (poly_value_o),
    .poly_index_o (poly_index_o),
    .last_o       (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #80_000_000;
    $display("legendre_polynomial_sequence verification failed");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      ledger.check_term(poly_value_o, poly_index_o, last_o);
  end

  // sink: random back-pressure, plus long hold-offs on request
  initial begin
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_sink) begin
        hold_sink = 1'b0;
        out_ready_i <= 1'b0;
        repeat (600) @(posedge clk_i);
      end else begin
        out_ready_i <= no_idle || ($urandom_range(99) >= 37);
        @(posedge clk_i);
      end
    end
  end

  task automatic send_request(input logic signed [X_W-1:0] x, input logic [DEG_W-1:0] d);
    in_valid_i <= 1'b1;
    x_value_i  <= x;
    degree_i   <= d;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    ledger.note_request(x, d);
  endtask

  task automatic sender_gap();
    if (!no_idle && $urandom_range(99) < 37) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
  endtask

  function automatic logic signed [X_W-1:0] random_x();
    case ($urandom_range(3))
      0:       return X_W'($urandom);
      1:       return X_MAX - X_W'($urandom_range(4095));
      2:       return X_MIN + X_W'($urandom_range(4095));
      default: return X_W'(int'($urandom_range(8191)) - 4096);
    endcase
  endfunction

  function automatic logic [DEG_W-1:0] random_degree();
    int r;
    r = $urandom_range(99);
    // mostly short sequences, a few long ones
    if (r < 70) return DEG_W'($urandom_range(12));
    if (r < 90) return DEG_W'($urandom_range(40, 13));
    return DEG_W'($urandom_range(TOP_DEGREE, 41));
  endfunction

  initial begin
    logic signed [X_W-1:0]   dir_x[$];
    logic        [DEG_W-1:0] dir_d[$];
    int                      guard;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // extremes of x and degree, degree zero, saturation near plus and minus one
    dir_x = '{'0, X_MIN, X_MAX, X_MIN, '0, X_MAX, X_MIN, '0,
              X_W'(2 ** (FRAC_BITS - 1)), X_W'(-(2 ** (FRAC_BITS - 1))),
              X_W'(1), X_W'(-1), X_MAX - X_W'(1), X_MIN + X_W'(1),
              X_W'(536870913), X_W'(-715827883), X_W'(123456789), X_MAX};
    dir_d = '{6'd0, 6'd0, 6'd1, 6'd1, 6'd2, 6'd63, 6'd63, 6'd63,
              6'd63, 6'd17, 6'd5, 6'd5, 6'd40, 6'd40,
              6'd33, 6'd63, 6'd2, 6'd0};
    foreach (dir_x[i]) begin
      send_request(dir_x[i], dir_d[i]);
      sender_gap();
    end

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      no_idle = (n >= 200 && n < 280);
      if (n == 100 || n == 350) hold_sink = 1'b1;
      send_request(random_x(), random_degree());
      sender_gap();
    end
    in_valid_i <= 1'b0;
    no_idle = 1'b0;

    guard = 0;
    while (ledger.awaited_terms.size() != 0 && guard < 200_000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (60) @(posedge clk_i);

    if (ledger.mismatches == 0 && ledger.awaited_terms.size() == 0) begin
      $display("legendre_polynomial_sequence verification clean");
    end else begin
      $display("legendre_polynomial_sequence verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/lps_pkg.sv
rtl/lps_datapath.sv
rtl/lps_ctrl.sv
rtl/legendre_polynomial_sequence.sv
test/testbench.sv
